FILE: rtl/lmbs_pkg.sv
// lmbs_pkg: shared types, codes and helpers of the local map box slider
// no dependencies; used by every module under rtl

package lmbs_pkg;

   localparam int COORD_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;
   localparam int THR_FRAC   = 12;
   localparam int DT_W       = 35;   // near distance width, unsigned
   localparam int HALF_W     = 30;   // half of cube_length
   localparam int AXES       = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CUBE_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_RANGE   = 2'd2;

   localparam logic [30:0] CUBE_LENGTH_RST    = 31'd65536000;
   localparam logic [15:0] MOVE_THRESHOLD_RST = 16'd6144;
   localparam logic [30:0] DETECT_RANGE_RST   = 31'd19660800;

   localparam logic [1:0] KIND_INIT   = 2'd0;
   localparam logic [1:0] KIND_NOMOVE = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_NEW    = 2'd3;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_max_z;
      logic               last_of_run;
   } rsp_type;

   // what one axis lane reports
   typedef struct packed {
      logic        near;
      logic        low;
      logic [31:0] new_min;
      logic [31:0] new_max;
      logic [31:0] rm_coord;
   } lane_res_type;

   // everything the emitter needs to play out one item's results
   typedef struct packed {
      logic [1:0]             final_kind;
      logic [AXES-1:0]        near;
      logic [AXES-1:0]        low;
      logic [AXES-1:0][31:0]  old_min;
      logic [AXES-1:0][31:0]  old_max;
      logic [AXES-1:0][31:0]  rm_coord;
      logic [AXES-1:0][31:0]  new_min;
      logic [AXES-1:0][31:0]  new_max;
   } batch_type;

   // clamp a 33-bit signed sum to the signed 32-bit range
   function automatic logic [31:0] sat33(input logic signed [32:0] v);
      logic [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/local_map_box_slider.sv
// local_map_box_slider: top level; input register, cube state, three axis
// lanes, derived-distance unit and the result emitter
// depends on lmbs_pkg, lmbs_derive, lmbs_lane, lmbs_emit
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     req_data  (lmbs_pkg::req_type)
//   rsp      out        rsp_valid / rsp_stall     rsp_data  (lmbs_pkg::rsp_type)
//   csr      in         csr_write_en              csr_index, csr_wdata
//
// an item gives 1 result (first or no move) or 1 to 3 removal boxes plus new corners;
// the emitter puts out one result per cycle while rsp_stall is low
// an accepted item reaches rsp_data through item_ff, the emitter's batch_ff and out_ff
// after reset and each config register write, req_stall is high while the derive unit runs
// req_stall also rises while an item waits and the emitter still plays out an earlier item

module local_map_box_slider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lmbs_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lmbs_pkg::rsp_type                rsp_data,
   input  logic                             csr_write_en,
   input  logic [lmbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lmbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                                  item_vld_ff, item_vld_in;
   lmbs_pkg::req_type                     item_ff, item_in;
   logic                                  map_ready_ff, map_ready_in;
   logic [lmbs_pkg::AXES-1:0][31:0]       cube_min_ff, cube_min_in;
   logic [lmbs_pkg::AXES-1:0][31:0]       cube_max_ff, cube_max_in;

   logic                                  drv_busy;
   logic [lmbs_pkg::DT_W-1:0]             near_dist;
   logic [31:0]                           shift_dist;
   logic [lmbs_pkg::HALF_W-1:0]           half_len;
   logic [lmbs_pkg::AXES-1:0][31:0]       pos;
   lmbs_pkg::lane_res_type                lane_res [lmbs_pkg::AXES];
   lmbs_pkg::batch_type                   batch;
   logic                                  batch_take, batch_load, accept;

   lmbs_derive u_derive (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .busy         (drv_busy),
      .near_dist    (near_dist),
      .shift_dist   (shift_dist),
      .half_len     (half_len)
   );

   assign pos[0] = item_ff.pos_x;
   assign pos[1] = item_ff.pos_y;
   assign pos[2] = item_ff.pos_z;

   for (genvar g = 0; g < lmbs_pkg::AXES; g++) begin : g_lane
      lmbs_lane u_lane (
         .pos        (pos[g]),
         .cube_min   (cube_min_ff[g]),
         .cube_max   (cube_max_ff[g]),
         .map_ready  (map_ready_ff),
         .near_dist  (near_dist),
         .shift_dist (shift_dist),
         .half_len   (half_len),
         .res        (lane_res[g])
      );
   end

   always_comb begin
      for (int i = 0; i < lmbs_pkg::AXES; i++) begin
         batch.near[i]     = lane_res[i].near;
         batch.low[i]      = lane_res[i].low;
         batch.old_min[i]  = cube_min_ff[i];
         batch.old_max[i]  = cube_max_ff[i];
         batch.rm_coord[i] = lane_res[i].rm_coord;
         batch.new_min[i]  = lane_res[i].new_min;
         batch.new_max[i]  = lane_res[i].new_max;
      end
      if (!map_ready_ff) begin
         batch.final_kind = lmbs_pkg::KIND_INIT;
      end else if (batch.near != '0) begin
         batch.final_kind = lmbs_pkg::KIND_NEW;
      end else begin
         batch.final_kind = lmbs_pkg::KIND_NOMOVE;
      end

      batch_load = item_vld_ff && batch_take;
      req_stall  = drv_busy || (item_vld_ff && !batch_take);
      accept     = req_valid && !req_stall;

      item_vld_in = accept || (item_vld_ff && !batch_take);
      item_in     = accept ? req_data : item_ff;

      // cube state moves on as soon as the item's results are handed over
      map_ready_in = map_ready_ff || batch_load;
      cube_min_in  = batch_load ? batch.new_min : cube_min_ff;
      cube_max_in  = batch_load ? batch.new_max : cube_max_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff  <= 1'b0;
         map_ready_ff <= 1'b0;
         cube_min_ff  <= '0;
         cube_max_ff  <= '0;
      end else begin
         item_vld_ff  <= item_vld_in;
         map_ready_ff <= map_ready_in;
         cube_min_ff  <= cube_min_in;
         cube_max_ff  <= cube_max_in;
      end
      item_ff <= item_in;
   end

   lmbs_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .batch_load (batch_load),
      .batch      (batch),
      .batch_take (batch_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      map_ready_ff |=> map_ready_ff)
      else $error("map ready dropped without reset");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_of_run ==
                     (rsp_data.result_kind != lmbs_pkg::KIND_REMOVE)))
      else $error("last flag does not match result kind");

   a_init_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_kind == lmbs_pkg::KIND_INIT) |-> map_ready_ff)
      else $error("init result without map ready");

   a_batch_held: assert property (@(posedge clock) disable iff (reset)
      item_vld_ff && !batch_take |=> item_vld_ff && $stable(item_ff))
      else $error("pending item lost before the emitter took it");

endmodule

FILE: rtl/lmbs_derive.sv
// lmbs_derive: configuration registers and the derived near and shift distances,
// built by a short sequencer with a reciprocal multiply for the divide by 5
// depends on lmbs_pkg

module lmbs_derive (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [lmbs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lmbs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                               busy,
   output logic [lmbs_pkg::DT_W-1:0]          near_dist,
   output logic [31:0]                        shift_dist,
   output logic [lmbs_pkg::HALF_W-1:0]        half_len
);

   typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_PREP, ST_DIV, ST_FIN} st_type;

   // floor(x / 5) is (x * 0xcc_cccc_cccd) >> 42 for every x below 2^42;
   // the product is summed from four 20 by 20 bit pieces, one per cycle
   localparam int MAG_W = 39;
   localparam int ACC_W = 79;
   localparam logic [19:0] RECIP_LO = 20'hccccd;
   localparam logic [19:0] RECIP_HI = 20'hccccc;

   st_type                          state_ff, state_in;
   logic [30:0]                     cube_length_ff, cube_length_in;
   logic [15:0]                     move_threshold_ff, move_threshold_in;
   logic [30:0]                     detect_range_ff, detect_range_in;
   logic [lmbs_pkg::DT_W-1:0]       dt_ff, dt_in;
   logic signed [35:0]              t2_ff, t2_in;
   logic [MAG_W-1:0]                mag_ff, mag_in;
   logic [ACC_W-1:0]                acc_ff, acc_in;
   logic [1:0]                      cnt_ff, cnt_in;
   logic                            neg_ff, neg_in;
   logic [31:0]                     md_ff, md_in;

   logic [46:0]        prod_dt;
   logic signed [16:0] thr_m;
   logic signed [47:0] prod_t2;
   logic signed [36:0] a_val;
   logic signed [40:0] a9;
   logic signed [38:0] q_val;
   logic [MAG_W-1:0]   mag;
   logic [19:0]        pp_a, pp_b;
   logic [39:0]        pp;
   logic [ACC_W-1:0]   pp_sh;
   logic [36:0]        quot;
   logic signed [38:0] t1;
   logic signed [38:0] t2x;
   logic signed [38:0] mx;

   always_comb begin
      prod_dt = 47'(move_threshold_ff) * 47'(detect_range_ff);
      thr_m   = $signed({1'b0, move_threshold_ff}) - 17'sd4096;
      prod_t2 = 48'(thr_m) * 48'($signed({1'b0, detect_range_ff}));

      a_val = $signed({6'd0, cube_length_ff}) - $signed({1'b0, dt_ff, 1'b0});
      a9    = (41'(a_val) <<< 3) + 41'(a_val);
      q_val = a9[40:2];
      // floor of a negative quotient: divide |q|+4 and negate
      mag   = q_val[38] ? (~q_val + 39'd5) : q_val;

      // pieces: low*low, low*high, high*low, high*high
      pp_a = cnt_ff[1] ? {1'b0, mag_ff[38:20]} : mag_ff[19:0];
      pp_b = cnt_ff[0] ? RECIP_HI : RECIP_LO;
      pp   = 40'(pp_a) * 40'(pp_b);
      case (cnt_ff)
         2'd0: begin
            pp_sh = ACC_W'(pp);
         end
         2'd3: begin
            pp_sh = ACC_W'(pp) << 40;
         end
         default: begin
            pp_sh = ACC_W'(pp) << 20;
         end
      endcase

      quot = acc_ff[ACC_W-1:42];
      t1   = neg_ff ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
      t2x  = 39'(t2_ff);
      mx   = (t1 > t2x) ? t1 : t2x;

      state_in          = state_ff;
      cube_length_in    = cube_length_ff;
      move_threshold_in = move_threshold_ff;
      detect_range_in   = detect_range_ff;
      dt_in             = dt_ff;
      t2_in             = t2_ff;
      mag_in            = mag_ff;
      acc_in            = acc_ff;
      cnt_in            = cnt_ff;
      neg_in            = neg_ff;
      md_in             = md_ff;

      case (state_ff)
         ST_IDLE: begin
         end
         ST_MUL: begin
            dt_in    = prod_dt[46:lmbs_pkg::THR_FRAC];
            t2_in    = prod_t2[47:lmbs_pkg::THR_FRAC];
            state_in = ST_PREP;
         end
         ST_PREP: begin
            mag_in   = mag;
            acc_in   = '0;
            cnt_in   = 2'd0;
            neg_in   = q_val[38];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            acc_in = acc_ff + pp_sh;
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (mx[38:31] != {8{mx[38]}}) begin
               md_in = mx[38] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
               md_in = mx[31:0];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a write to a configuration register restarts the derivation from the top
      if (csr_write_en) begin
         case (csr_index)
            lmbs_pkg::CSR_CUBE_LENGTH: begin
               cube_length_in = csr_wdata;
               state_in       = ST_MUL;
            end
            lmbs_pkg::CSR_MOVE_THRESHOLD: begin
               move_threshold_in = csr_wdata[15:0];
               state_in          = ST_MUL;
            end
            lmbs_pkg::CSR_DETECT_RANGE: begin
               detect_range_in = csr_wdata;
               state_in        = ST_MUL;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_MUL;
         cube_length_ff    <= lmbs_pkg::CUBE_LENGTH_RST;
         move_threshold_ff <= lmbs_pkg::MOVE_THRESHOLD_RST;
         detect_range_ff   <= lmbs_pkg::DETECT_RANGE_RST;
      end else begin
         state_ff          <= state_in;
         cube_length_ff    <= cube_length_in;
         move_threshold_ff <= move_threshold_in;
         detect_range_ff   <= detect_range_in;
      end
      dt_ff  <= dt_in;
      t2_ff  <= t2_in;
      mag_ff <= mag_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      md_ff  <= md_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign near_dist  = dt_ff;
   assign shift_dist = md_ff;
   assign half_len   = cube_length_ff[30:1];

endmodule

FILE: rtl/lmbs_lane.sv
// lmbs_lane: one axis of the cube; face distances, move decision,
// shifted corners and the removal coordinate
// depends on lmbs_pkg

module lmbs_lane (
   input  logic [31:0]                 pos,
   input  logic [31:0]                 cube_min,
   input  logic [31:0]                 cube_max,
   input  logic                        map_ready,
   input  logic [lmbs_pkg::DT_W-1:0]   near_dist,
   input  logic [31:0]                 shift_dist,
   input  logic [lmbs_pkg::HALF_W-1:0] half_len,
   output lmbs_pkg::lane_res_type      res
);

   logic signed [32:0] pos_s, min_s, max_s, md_s, half_s;
   logic signed [32:0] dl, dh;
   logic [32:0]        dl_abs, dh_abs;
   logic               near_low, near_high;
   logic [31:0]        min_dn, max_dn, min_up, max_up, init_min, init_max;

   always_comb begin
      pos_s  = $signed({pos[31], pos});
      min_s  = $signed({cube_min[31], cube_min});
      max_s  = $signed({cube_max[31], cube_max});
      md_s   = $signed({shift_dist[31], shift_dist});
      half_s = $signed({3'd0, half_len});

      dl     = pos_s - min_s;
      dh     = pos_s - max_s;
      dl_abs = dl[32] ? 33'(-dl) : 33'(dl);
      dh_abs = dh[32] ? 33'(-dh) : 33'(dh);

      // low face wins when both are near
      near_low  = ({2'd0, dl_abs} <= near_dist);
      near_high = !near_low && ({2'd0, dh_abs} <= near_dist);

      min_dn   = lmbs_pkg::sat33(min_s - md_s);
      max_dn   = lmbs_pkg::sat33(max_s - md_s);
      min_up   = lmbs_pkg::sat33(min_s + md_s);
      max_up   = lmbs_pkg::sat33(max_s + md_s);
      init_min = lmbs_pkg::sat33(pos_s - half_s);
      init_max = lmbs_pkg::sat33(pos_s + half_s);

      if (!map_ready) begin
         res.near     = 1'b0;
         res.low      = 1'b0;
         res.new_min  = init_min;
         res.new_max  = init_max;
         res.rm_coord = init_min;
      end else begin
         res.near     = near_low | near_high;
         res.low      = near_low;
         res.new_min  = near_low ? min_dn : (near_high ? min_up : cube_min);
         res.new_max  = near_low ? max_dn : (near_high ? max_up : cube_max);
         res.rm_coord = near_low ? max_dn : min_up;
      end
   end

endmodule

FILE: rtl/lmbs_emit.sv
// lmbs_emit: merging stage; holds one item's lane results and plays out
// removal boxes per shifted axis, then the final corners, into an output register
// depends on lmbs_pkg

module lmbs_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   batch_load,
   input  lmbs_pkg::batch_type    batch,
   output logic                   batch_take,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lmbs_pkg::rsp_type      rsp_data
);

   logic                         batch_vld_ff, batch_vld_in;
   lmbs_pkg::batch_type          batch_ff, batch_in;
   logic [lmbs_pkg::AXES-1:0]    rem_ff, rem_in;
   logic                         out_vld_ff, out_vld_in;
   lmbs_pkg::rsp_type            out_ff, out_in;

   logic                         out_free, emit, last, done;
   logic [1:0]                   axis;
   logic [lmbs_pkg::AXES-1:0][31:0] bmin, bmax;
   lmbs_pkg::rsp_type            sel;

   always_comb begin
      out_free = !out_vld_ff || !rsp_stall;
      emit     = batch_vld_ff && out_free;
      last     = (rem_ff == '0);
      done     = emit && last;
      axis     = rem_ff[0] ? 2'd0 : (rem_ff[1] ? 2'd1 : 2'd2);

      if (last) begin
         bmin = batch_ff.new_min;
         bmax = batch_ff.new_max;
      end else begin
         bmin = batch_ff.old_min;
         bmax = batch_ff.old_max;
         if (batch_ff.low[axis]) begin
            bmin[axis] = batch_ff.rm_coord[axis];
         end else begin
            bmax[axis] = batch_ff.rm_coord[axis];
         end
      end

      sel.result_kind = last ? batch_ff.final_kind : lmbs_pkg::KIND_REMOVE;
      sel.box_min_x   = bmin[0];
      sel.box_min_y   = bmin[1];
      sel.box_min_z   = bmin[2];
      sel.box_max_x   = bmax[0];
      sel.box_max_y   = bmax[1];
      sel.box_max_z   = bmax[2];
      sel.last_of_run = last;

      batch_take = !batch_vld_ff || done;

      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (emit) begin
         out_vld_in = 1'b1;
         out_in     = sel;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end

      batch_vld_in = batch_vld_ff;
      batch_in     = batch_ff;
      rem_in       = rem_ff;
      if (emit && !last) begin
         // drop the lowest pending axis
         rem_in = rem_ff & (rem_ff - 3'd1);
      end
      if (batch_load) begin
         batch_vld_in = 1'b1;
         batch_in     = batch;
         rem_in       = batch.near;
      end else if (done) begin
         batch_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_vld_ff <= 1'b0;
         out_vld_ff   <= 1'b0;
         rem_ff       <= '0;
      end else begin
         batch_vld_ff <= batch_vld_in;
         out_vld_ff   <= out_vld_in;
         rem_ff       <= rem_in;
      end
      batch_ff <= batch_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule
